/* rtl/a2fa_pkg.sv */
// Package for the atan2 approximation unit: shared formats, angle constants and the flag type.
`default_nettype none

package a2fa_pkg;

    // Default sample and output formats.
    localparam int SAMPLE_WIDTH_DEF    = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 13;

    // Internal angle arithmetic runs in Q30.
    localparam int IFRAC = 30;
    // The ratio reaches exactly 1.0, so it takes one bit above the fraction.
    localparam int QW    = IFRAC + 1;
    // An angle up to pi in Q30 needs two integer bits.
    localparam int AIW   = IFRAC + 2;

    // Q30 constants, rounded to nearest.
    localparam logic [AIW-1:0] Q30_ONE  = 32'd1073741824;
    localparam logic [AIW-1:0] Q30_PI   = 32'd3373259426;
    localparam logic [AIW-1:0] Q30_PI2  = 32'd1686629713;
    localparam logic [AIW-1:0] Q30_PI4  = 32'd843314857;
    localparam logic [AIW-1:0] Q30_CORR = 32'd293131518;

    // Per-word flags that travel alongside the data.
    typedef struct packed {
        logic zero;   // both components are zero
        logic swap;   // |y| > |x|, so the octant is unfolded at the end
        logic xneg;   // x is negative, mirror about pi/2
        logic yneg;   // y is negative, negate the final angle
    } t_flags;

endpackage

`default_nettype wire

/* rtl/atan2_fast_approximation_unit.sv */
// Top level of the atan2 approximation unit: a pipelined four-quadrant phase angle.
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+------------------------------
//  in      | to unit   | i_in_valid / o_in_stall   | i_y_value, i_x_value (signed)
//  out     | from unit | o_out_valid / i_out_stall | o_angle (signed Q2.ANGLE_FRAC_BITS)
//
// The unit accepts one word per clock cycle while o_in_stall is low and returns one angle
// per word, in order. The pipeline has one prep stage, one stage per quotient bit of the
// restoring divider (IFRAC + 1 of them), two multiply stages with an add stage between
// them, a fold stage and a rounding stage. The synchronous active-low reset clears only
// the valid bits; the payload registers are not reset.
// A stalled output holds its word. Each stage moves whenever it or any stage after it
// is empty, so bubbles close up and new words are taken while a finished angle waits.
`default_nettype none

module atan2_fast_approximation_unit
    import a2fa_pkg::*;
#(
    parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  wire  signed [SAMPLE_WIDTH-1:0]       i_y_value,
    input  wire  signed [SAMPLE_WIDTH-1:0]       i_x_value,
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output logic signed [ANGLE_FRAC_BITS+2:0]    o_angle
);

    // Output width and rounding shift.
    localparam int AW  = ANGLE_FRAC_BITS + 3;
    localparam int SH  = IFRAC - ANGLE_FRAC_BITS;
    // Rounding sum keeps one carry bit above the Q30 angle.
    localparam int RSW = AIW + 1;
    // Divider remainder needs one bit above the sample magnitude.
    localparam int RW  = SAMPLE_WIDTH + 1;
    // Number of quotient bits, one divider stage each.
    localparam int NQ  = QW;

    // Stage indices: 0 is prep, 1..NQ is the divider, then the arithmetic tail.
    localparam int S_M1  = NQ + 1;
    localparam int S_ADD = NQ + 2;
    localparam int S_M2  = NQ + 3;
    localparam int S_FLD = NQ + 4;
    localparam int S_RND = NQ + 5;
    localparam int NST   = NQ + 6;

    localparam logic [RSW-1:0]       RND_HALF = RSW'(1) << (SH - 1);
    localparam logic [NST-1:0]       ALL_ONES = {NST{1'b1}};
    localparam logic signed [AW-1:0] ANG_MAX  =
        AW'((RSW'(Q30_PI) + RND_HALF) >> SH);

    // Valid bits and per-stage load enables.
    logic [NST-1:0] r_v;
    logic [NST-1:0] w_en;

    // Prep and divider stages.
    logic [RW-1:0]           r_rem [0:NQ];
    logic [SAMPLE_WIDTH-1:0] r_den [0:NQ];
    logic [QW-1:0]           r_q   [1:NQ];
    t_flags                  r_fl  [0:S_FLD];

    logic [RW-1:0]           n_rem [1:NQ];
    logic [QW-1:0]           n_q   [1:NQ];

    // Arithmetic tail.
    logic [QW-1:0]  r_m1_term,  n_m1_term;
    logic [QW-1:0]  r_m1_ratio;
    logic [QW:0]    r_ad_sum,   n_ad_sum;
    logic [QW-1:0]  r_ad_ratio;
    logic [QW-1:0]  r_m2_atan,  n_m2_atan;
    logic [AIW-1:0] r_fd_ang,   n_fd_ang;
    logic [AW-1:0]  r_angle,    n_angle;

    // Prep stage signals.
    logic                    n_yneg, n_xneg, n_swap;
    logic [SAMPLE_WIDTH-1:0] n_ay, n_ax;
    t_flags                  n_fl0;
    logic [RW-1:0]           n_rem0;
    logic [SAMPLE_WIDTH-1:0] n_den0;

    logic [2*QW-1:0] w_prod1;
    logic [2*QW:0]   w_prod2;
    logic [AIW-1:0]  w_fold_op;
    logic [RSW-1:0]  w_rsum;
    logic [AW-1:0]   w_mag;

    // A stage may load when the output is free or some stage at or after it is empty.
    always_comb begin
        for (int k = 0; k < NST; k++) begin
            w_en[k] = !i_out_stall || !(&(r_v | (ALL_ONES >> (NST - k))));
        end
    end

    assign o_in_stall  = !w_en[0];
    assign o_out_valid = r_v[S_RND];
    assign o_angle     = r_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Prep: magnitudes, octant swap and flags. The most negative sample maps to
    // its exact magnitude because the result is read as unsigned.
    always_comb begin
        n_yneg = i_y_value[SAMPLE_WIDTH-1];
        n_xneg = i_x_value[SAMPLE_WIDTH-1];
        n_ay   = n_yneg ? (SAMPLE_WIDTH'(0) - i_y_value) : i_y_value;
        n_ax   = n_xneg ? (SAMPLE_WIDTH'(0) - i_x_value) : i_x_value;
        n_swap = n_ay > n_ax;
        n_fl0.zero = (n_ay == '0) && (n_ax == '0);
        n_fl0.swap = n_swap;
        n_fl0.xneg = n_xneg;
        n_fl0.yneg = n_yneg;
        n_rem0 = {1'b0, (n_swap ? n_ax : n_ay)};
        n_den0 = n_swap ? n_ay : n_ax;
    end

    // Restoring divider, one quotient bit per stage. The numerator never exceeds
    // the denominator, so the first stage compares without a shift.
    for (genvar j = 1; j <= NQ; j++) begin : g_div
        logic [RW-1:0] w_trial;
        logic          w_ge;
        if (j == 1) begin : g_first
            assign w_trial = r_rem[0];
            assign n_q[j]  = QW'(w_ge);
        end else begin : g_rest
            assign w_trial = {r_rem[j-1][RW-2:0], 1'b0};
            assign n_q[j]  = {r_q[j-1][QW-2:0], w_ge};
        end
        assign w_ge     = w_trial >= {1'b0, r_den[j-1]};
        assign n_rem[j] = w_ge ? (w_trial - {1'b0, r_den[j-1]}) : w_trial;
    end

    // Correction term, sum, product, octant fold and rounding.
    always_comb begin
        w_prod1   = (2*QW)'(Q30_CORR[QW-1:0]) * (2*QW)'(Q30_ONE[QW-1:0] - r_q[NQ]);
        n_m1_term = w_prod1[IFRAC +: QW];

        n_ad_sum  = (QW+1)'(Q30_PI4) + (QW+1)'(r_m1_term);

        w_prod2   = (2*QW+1)'(r_ad_ratio) * (2*QW+1)'(r_ad_sum);
        n_m2_atan = w_prod2[IFRAC +: QW];

        // pi - pi/2 equals pi/2 in Q30, so the swapped and mirrored case is pi/2 + atan.
        if (r_fl[S_M2].swap) begin
            w_fold_op = Q30_PI2;
        end else begin
            w_fold_op = r_fl[S_M2].xneg ? Q30_PI : '0;
        end
        if (r_fl[S_M2].swap == r_fl[S_M2].xneg && r_fl[S_M2].swap) begin
            n_fd_ang = w_fold_op + AIW'(r_m2_atan);
        end else if (r_fl[S_M2].swap || r_fl[S_M2].xneg) begin
            n_fd_ang = w_fold_op - AIW'(r_m2_atan);
        end else begin
            n_fd_ang = AIW'(r_m2_atan);
        end

        w_rsum = RSW'(r_fd_ang) + RND_HALF;
        w_mag  = w_rsum[SH +: AW];
        if (r_fl[S_FLD].zero) begin
            n_angle = '0;
        end else begin
            n_angle = r_fl[S_FLD].yneg ? (AW'(0) - w_mag) : w_mag;
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_rem[0] <= n_rem0;
            r_den[0] <= n_den0;
            r_fl[0]  <= n_fl0;
        end
        for (int j = 1; j <= NQ; j++) begin
            if (w_en[j]) begin
                r_rem[j] <= n_rem[j];
                r_den[j] <= r_den[j-1];
                r_q[j]   <= n_q[j];
                r_fl[j]  <= r_fl[j-1];
            end
        end
        if (w_en[S_M1]) begin
            r_m1_term  <= n_m1_term;
            r_m1_ratio <= r_q[NQ];
            r_fl[S_M1] <= r_fl[NQ];
        end
        if (w_en[S_ADD]) begin
            r_ad_sum    <= n_ad_sum;
            r_ad_ratio  <= r_m1_ratio;
            r_fl[S_ADD] <= r_fl[S_M1];
        end
        if (w_en[S_M2]) begin
            r_m2_atan  <= n_m2_atan;
            r_fl[S_M2] <= r_fl[S_ADD];
        end
        if (w_en[S_FLD]) begin
            r_fd_ang    <= n_fd_ang;
            r_fl[S_FLD] <= r_fl[S_M2];
        end
        if (w_en[S_RND]) begin
            r_angle <= n_angle;
        end
    end

    // The input is held off only when every stage holds a word.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (&r_v))
        else $error("input stalled while the pipeline has a free stage");

    // The final remainder stays below a nonzero divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NQ] && !r_fl[NQ].zero) |-> (r_rem[NQ] < {1'b0, r_den[NQ]}))
        else $error("divider remainder out of range");

    // The ratio never exceeds one. The origin divides zero by zero, and its
    // quotient is ignored because the angle is forced to zero.
    a_ratio_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NQ] && !r_fl[NQ].zero) |-> (r_q[NQ] <= Q30_ONE[QW-1:0]))
        else $error("ratio above one");

    // Every delivered angle lies within plus or minus pi.
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_angle <= ANG_MAX) && (o_angle >= -ANG_MAX)))
        else $error("angle outside the range of plus or minus pi");

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking testbench for the atan2 fast approximation unit: stimulus, angle prediction, checking.
`timescale 1ns / 100ps

module testbench;
    import a2fa_pkg::*;

    // Block configuration under test and the derived widths.
    localparam int SW    = 16;
    localparam int AFB   = 13;
    localparam int AW    = AFB + 3;
    // The angle is worked out in Q30 before it is rounded to the output step.
    localparam int FRAC  = 30;
    localparam int SHIFT = FRAC - AFB;

    // Q30 angle constants, rounded to nearest.
    localparam longint unsigned K_ONE     = 64'd1073741824;
    localparam longint unsigned K_PI      = 64'd3373259426;
    localparam longint unsigned K_HALF_PI = 64'd1686629713;
    localparam longint unsigned K_QTR_PI  = 64'd843314857;
    localparam longint unsigned K_SLOPE   = 64'd293131518;

    // Cycles without any accepted word before the run is declared hung. The slowest
    // legitimate quiet stretch is the pipeline drain plus the tail.
    localparam int HANG_LIMIT = 2000;
    // Cycles to keep watching the output after the last angle, to catch strays.
    localparam int TAIL_CYCLES = 60;

    typedef struct packed {
        logic signed [SW-1:0] y;
        logic signed [SW-1:0] x;
    } sample_pair_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic signed [SW-1:0] y_value   = '0;
    logic signed [SW-1:0] x_value   = '0;
    logic                 out_stall = 1'b0;
    logic                 in_stall;
    logic                 out_valid;
    logic signed [AW-1:0] angle;

    // Words waiting to be offered, and angles waiting to come out, oldest first.
    sample_pair_t         pending_pairs[$];
    logic [AW-1:0]        expected_angles[$];

    // When set, neither side inserts gaps, so the pipeline runs at full rate.
    bit                   steady_run = 1'b0;

    int                   mismatches   = 0;
    int                   words_in     = 0;
    int                   angles_out   = 0;
    int                   axis_words   = 0;
    int                   quadrant_words[4];
    int                   quiet_cycles = 0;

    atan2_fast_approximation_unit #(
        .SAMPLE_WIDTH    (SW),
        .ANGLE_FRAC_BITS (AFB)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_y_value   (y_value),
        .i_x_value   (x_value),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_angle     (angle)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Angle predictor
    // ------------------------------------------------------------------

    // Exact magnitude of a two's complement sample; the most negative value
    // gets one more than the positive range and must not wrap.
    function automatic longint unsigned magnitude(logic [SW-1:0] v);
        longint unsigned wide;
        wide = 64'(v);
        return v[SW-1] ? ((64'd1 << SW) - wide) : wide;
    endfunction

    // atan(r) for r in [0, 1] as r * (pi/4 + 0.273 * (1 - r)), all in Q30,
    // each product truncated.
    function automatic longint unsigned octant_atan(longint unsigned ratio);
        longint unsigned corr;
        corr = (K_SLOPE * (K_ONE - ratio)) >> FRAC;
        return (ratio * (K_QTR_PI + corr)) >> FRAC;
    endfunction

    function automatic logic [AW-1:0] phase_of(sample_pair_t p);
        longint unsigned ay;
        longint unsigned ax;
        longint unsigned ang;
        longint unsigned mag;
        ay = magnitude(p.y);
        ax = magnitude(p.x);
        // The origin has no defined phase; the block reports zero for it.
        if (ay == 0 && ax == 0) begin
            return '0;
        end
        // Always divide the smaller magnitude by the larger one so the ratio
        // stays within [0, 1], then unfold the upper octant about pi/4.
        if (ay <= ax) begin
            ang = octant_atan((ay << FRAC) / ax);
        end else begin
            ang = K_HALF_PI - octant_atan((ax << FRAC) / ay);
        end
        // Left half plane: mirror about the vertical axis.
        if (p.x[SW-1]) begin
            ang = K_PI - ang;
        end
        // Round the magnitude half up, then apply the sign of y, so that the
        // rounding is symmetric about zero. Zero y on the left gives +pi.
        mag = (ang + (64'd1 << (SHIFT - 1))) >> SHIFT;
        return p.y[SW-1] ? AW'(64'd0 - mag) : AW'(mag);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_pair(int y, int x);
        sample_pair_t p;
        p.y = SW'(y);
        p.x = SW'(x);
        pending_pairs.push_back(p);
    endtask

    // One random component in the given style. Styles cover fully random bit
    // patterns, tiny values, the edges of the range and widely spread scales.
    function automatic int random_component(int style);
        int corner_vals[7];
        int v;
        corner_vals = '{-32768, -32767, -1, 0, 1, 32766, 32767};
        case (style)
            0: begin
                v = int'($signed(SW'($urandom)));
            end
            1: begin
                v = int'($urandom_range(16)) - 8;
            end
            2: begin
                v = corner_vals[$urandom_range(6)];
            end
            default: begin
                v = int'($urandom_range(32767) >> $urandom_range(14));
                if ($urandom_range(1) == 1) begin
                    v = -v;
                end
            end
        endcase
        return v;
    endfunction

    task automatic queue_random_pairs(int count);
        int roll;
        int a;
        int b;
        int y;
        int x;
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < 30) begin
                y = random_component(0);
                x = random_component(0);
            end else if (roll < 45) begin
                y = random_component(1);
                x = random_component(1);
            end else if (roll < 62) begin
                // Magnitudes almost equal: exercises the octant boundary where
                // the ratio sits at or next to one.
                a = $urandom_range(32767);
                b = a + int'($urandom_range(6)) - 3;
                if (b < 0) b = 0;
                if (b > 32767) b = 32767;
                y = ($urandom_range(1) == 1) ? -a : a;
                x = ($urandom_range(1) == 1) ? -b : b;
                if ($urandom_range(1) == 1) begin
                    a = y;
                    y = x;
                    x = a;
                end
            end else if (roll < 72) begin
                // One component on an axis.
                a = random_component($urandom_range(3));
                if ($urandom_range(1) == 1) begin
                    y = a;
                    x = 0;
                end else begin
                    y = 0;
                    x = a;
                end
            end else if (roll < 82) begin
                y = random_component(2);
                x = random_component(2);
            end else begin
                y = random_component(3);
                x = random_component(3);
            end
            queue_pair(y, x);
        end
    endtask

    // Holds the test sequence back until every queued word has come back as an angle.
    task automatic wait_for_drain();
        while (pending_pairs.size() != 0 || in_valid || expected_angles.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued words on the input channel
    // ------------------------------------------------------------------

    always @(posedge clk) begin
        sample_pair_t next_pair;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            // The current word, if any, is taken at this edge: predict its angle now.
            if (in_valid) begin
                expected_angles.push_back(phase_of({y_value, x_value}));
                words_in++;
                if (y_value == 0 || x_value == 0) begin
                    axis_words++;
                end else begin
                    quadrant_words[{y_value[SW-1], x_value[SW-1]}]++;
                end
            end
            // Refill the slot unless a random gap is due. A word that is still
            // stalled is never touched, so valid stays high through the stall.
            if (pending_pairs.size() != 0 && (steady_run || $urandom_range(99) >= 28)) begin
                next_pair = pending_pairs.pop_front();
                y_value   <= next_pair.y;
                x_value   <= next_pair.x;
                in_valid  <= 1'b1;
            end else begin
                in_valid  <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: takes angles off the output channel and checks them in order
    // ------------------------------------------------------------------

    always @(posedge clk) begin
        logic [AW-1:0] want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                angles_out++;
                if (expected_angles.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("ERROR: angle %0d arrived with no word outstanding",
                                 angle);
                    end
                end else begin
                    want = expected_angles.pop_front();
                    if (angle !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("ERROR: angle #%0d expected %0d got %0d",
                                     angles_out, $signed(want), angle);
                        end
                    end
                end
            end
            // The receiver backs off at random, independent of whether a word waits.
            out_stall <= !steady_run && ($urandom_range(99) < 28);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: a long stretch with no word moving on either side is a hang.
    // ------------------------------------------------------------------

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("ERROR: no word accepted for %0d cycles, %0d angles still owed",
                     HANG_LIMIT, expected_angles.size());
            $display("atan2_fast_approximation_unit regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial begin
        // Directed words: the origin, both axes in both directions, the most
        // negative samples, the corners of the square, equal magnitudes on every
        // diagonal, and points just above and below the negative x axis where
        // the angle sits next to plus or minus pi.
        queue_pair(0, 0);
        queue_pair(0, 32767);
        queue_pair(0, -32768);
        queue_pair(32767, 0);
        queue_pair(-32768, 0);
        queue_pair(1, 0);
        queue_pair(-1, 0);
        queue_pair(0, 1);
        queue_pair(0, -1);
        queue_pair(-32768, -32768);
        queue_pair(32767, 32767);
        queue_pair(-32768, 32767);
        queue_pair(32767, -32768);
        queue_pair(1, -32768);
        queue_pair(-1, -32768);
        queue_pair(-32768, 1);
        queue_pair(32767, -1);
        queue_pair(100, 100);
        queue_pair(-100, -100);
        queue_pair(100, -100);
        queue_pair(-100, 100);
        queue_pair(1, 32767);
        queue_pair(-32767, -32768);
        queue_pair(12345, -23456);
        queue_pair(-30000, -7);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Let the directed words run out completely before the random traffic,
        // so the sender sits idle while the whole pipeline empties.
        wait_for_drain();

        queue_random_pairs(400);
        wait_for_drain();

        // A stretch at full rate: no gaps on the input, no stalls on the output.
        steady_run = 1'b1;
        queue_random_pairs(300);
        wait_for_drain();
        steady_run = 1'b0;

        queue_random_pairs(450);
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d angles for %0d words: %0d on an axis, quadrants %0d/%0d/%0d/%0d",
                 angles_out, words_in, axis_words, quadrant_words[0], quadrant_words[1],
                 quadrant_words[2], quadrant_words[3]);
        $display("Traffic mixed random gaps and stalls with a full-rate stretch; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && expected_angles.size() == 0) begin
            $display("atan2_fast_approximation_unit regression: pass");
        end else begin
            $display("atan2_fast_approximation_unit regression: fail");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/a2fa_pkg.sv
rtl/atan2_fast_approximation_unit.sv
bench/testbench.sv
